@@ rtl/core/hsvh_pkg.sv @@
package hsvh_pkg;

  // Store geometry
  localparam int MAX_HUE    = 16;
  localparam int MAX_SAT    = 8;
  localparam int MAX_VAL    = 8;
  localparam int COUNT_BITS = 24;
  localparam int NUM_BINS   = MAX_HUE * MAX_SAT * MAX_VAL + MAX_VAL + 1;

  // Field widths
  localparam int HUE_W   = 5;
  localparam int SAT_W   = 4;
  localparam int VAL_W   = 4;
  localparam int BIN_W   = 11;
  localparam int CMD_W   = 2;
  localparam int SHARE_W = 17;
  localparam int FRAC_W  = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;

  // Divider: one quotient bit per step over the whole shifted dividend
  localparam int DIV_STEPS = COUNT_BITS + FRAC_W;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  // Commands
  typedef enum logic [CMD_W-1:0] {
    CMD_ADD   = 2'd0,
    CMD_READ  = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_t;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HUE_LEVELS = 2'd0,
    REG_SAT_LEVELS = 2'd1,
    REG_VAL_LEVELS = 2'd2,
    REG_UNUSED     = 2'd3
  } reg_idx_t;

  // Reset values of the level registers
  localparam logic [HUE_W-1:0] HUE_RESET = 5'd8;
  localparam logic [SAT_W-1:0] SAT_RESET = 4'd3;
  localparam logic [VAL_W-1:0] VAL_RESET = 4'd3;

endpackage

@@ rtl/core/hsv_color_gray_histogram.sv @@
// HSV color/gray histogram accumulator.
// Input channel (in_valid/in_stall): cmd with hue_q, sat_q, val_q, read_bin.
// A transfer happens when in_valid is high and in_stall is low. cmd add
// counts one pixel, read returns one bin, clear zeroes all bins and the total.
// Output channel (out_valid/out_stall): one result per read: bin_id,
// bin_count, bin_share (Q1.16 count/total) and empty_flag.
// Config port (cfg_valid/cfg_ready, always ready): cfg_index 0..2 selects
// hue_levels, sat_levels, val_levels; write only while the block is idle.
// Steps, all through one sequencer and one single-port-pair bin RAM:
//   add   : index multiply over states IDX1, IDX2 and IDX3, then a
//           read-modify-write of the bin RAM.
//   read  : bin RAM read, then the bit-serial divider (40 steps) unless the total is zero.
//   clear : one RAM entry written per cycle, over every bin.
// After reset the same clearing pass runs with in_stall high.
// The result sits in an output register; while the receiver stalls, the
// block keeps taking adds and clears, and a second read waits at its end.
module hsv_color_gray_histogram import hsvh_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  // input items
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [CMD_W-1:0]      cmd,
  input  logic [HUE_W-1:0]      hue_q,
  input  logic [SAT_W-1:0]      sat_q,
  input  logic [VAL_W-1:0]      val_q,
  input  logic [BIN_W-1:0]      read_bin,
  // results
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [BIN_W-1:0]      bin_id,
  output logic [COUNT_BITS-1:0] bin_count,
  output logic [SHARE_W-1:0]    bin_share,
  output logic                  empty_flag,
  // configuration
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  typedef enum logic [9:0] {
    ST_CLR   = 10'b0000000001,
    ST_IDLE  = 10'b0000000010,
    ST_IDX1  = 10'b0000000100,
    ST_IDX2  = 10'b0000001000,
    ST_IDX3  = 10'b0000010000,
    ST_RD    = 10'b0000100000,
    ST_WR    = 10'b0001000000,
    ST_LOAD  = 10'b0010000000,
    ST_DIV   = 10'b0100000000,
    ST_DONE  = 10'b1000000000
  } state_t;

  typedef enum logic [1:0] {
    KIND_SKIP  = 2'd0,
    KIND_BLACK = 2'd1,
    KIND_GRAY  = 2'd2,
    KIND_COLOR = 2'd3
  } kind_t;

  state_t state, state_next;
  kind_t  kind, kind_next;

  logic [CMD_W-1:0]  cmd_r;
  logic [HUE_W-1:0]  hue_r;
  logic [SAT_W-1:0]  sat_r;
  logic [VAL_W-1:0]  val_r;
  logic [BIN_W-1:0]  rbin_r;
  logic              rbin_ok;

  logic [HUE_W-1:0]  hue_levels;
  logic [SAT_W-1:0]  sat_levels;
  logic [VAL_W-1:0]  val_levels;
  logic [HUE_W-1:0]  hue_use;
  logic [SAT_W-1:0]  sat_use;
  logic [VAL_W-1:0]  val_use;

  logic [SAT_W-1:0]  vm2;
  logic [SAT_W-1:0]  sm2;
  logic [2*SAT_W-1:0] prod_sv;
  logic [6:0]        t1;
  logic [8:0]        hs;
  logic [11:0]       prod_ht;
  logic [12:0]       prod_hsv;
  logic [BIN_W-1:0]  idx_color;
  logic [BIN_W-1:0]  ncol;
  logic [BIN_W-1:0]  bin_addr;
  logic [BIN_W-1:0]  clr_addr;

  logic [COUNT_BITS-1:0] total;
  logic [COUNT_BITS-1:0] rdata;
  logic [COUNT_BITS-1:0] res_count;
  logic                  res_empty;

  logic                  we;
  logic [BIN_W-1:0]      waddr;
  logic [COUNT_BITS-1:0] wdata;
  logic [BIN_W-1:0]      raddr;

  logic                  in_xfer;
  logic                  out_xfer;
  logic                  div_start;
  logic                  div_done;
  logic [SHARE_W-1:0]    quotient;

  logic v_black, v_ok, s_gray, s_ok, h_ok;

  assign in_stall  = (state != ST_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign out_xfer  = out_valid && !out_stall;
  assign cfg_ready = 1'b1;

  // Level counts in use, zero counts as one, large values saturate
  always_comb begin
    hue_use = hue_levels;
    if (hue_levels == '0) hue_use = HUE_W'(1);
    else if (hue_levels > HUE_W'(MAX_HUE)) hue_use = HUE_W'(MAX_HUE);
    sat_use = sat_levels;
    if (sat_levels == '0) sat_use = SAT_W'(1);
    else if (sat_levels > SAT_W'(MAX_SAT)) sat_use = SAT_W'(MAX_SAT);
    val_use = val_levels;
    if (val_levels == '0) val_use = VAL_W'(1);
    else if (val_levels > VAL_W'(MAX_VAL)) val_use = VAL_W'(MAX_VAL);
  end

  // Pixel classification
  assign v_black = (val_r == VAL_W'(1));
  assign v_ok    = (val_r >= VAL_W'(2)) && ({1'b0, val_r} <= {1'b0, val_use} + 5'd1);
  assign s_gray  = (sat_r == SAT_W'(1));
  assign s_ok    = (sat_r >= SAT_W'(2)) && ({1'b0, sat_r} <= {1'b0, sat_use} + 5'd1);
  assign h_ok    = (hue_r >= HUE_W'(1)) && (hue_r <= hue_use);

  always_comb begin
    if (v_black)           kind_next = KIND_BLACK;
    else if (!v_ok)        kind_next = KIND_SKIP;
    else if (s_gray)       kind_next = KIND_GRAY;
    else if (s_ok && h_ok) kind_next = KIND_COLOR;
    else                   kind_next = KIND_SKIP;
  end

  // Index arithmetic operands
  assign vm2      = val_r - VAL_W'(2);
  assign sm2      = sat_r - SAT_W'(2);
  assign prod_sv  = {4'd0, sat_use} * {4'd0, vm2};
  assign prod_ht  = {7'd0, hue_use} * {5'd0, t1};
  assign prod_hsv = {4'd0, hs} * {9'd0, val_use};

  // Sequencer
  always_comb begin
    state_next = state;
    div_start  = 1'b0;
    case (state)
      ST_CLR: begin
        if (clr_addr == BIN_W'(NUM_BINS - 1)) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_xfer) begin
          case (cmd)
            CMD_ADD:   state_next = ST_IDX1;
            CMD_READ:  state_next = ST_RD;
            CMD_CLEAR: state_next = ST_CLR;
            default:   state_next = ST_IDLE;
          endcase
        end
      end
      ST_IDX1: state_next = (kind_next == KIND_SKIP) ? ST_IDLE : ST_IDX2;
      ST_IDX2: state_next = ST_IDX3;
      ST_IDX3: state_next = ST_RD;
      ST_RD:   state_next = (cmd_r == CMD_READ) ? ST_LOAD : ST_WR;
      ST_WR:   state_next = ST_IDLE;
      ST_LOAD: begin
        if (total == '0) begin
          state_next = ST_DONE;
        end else begin
          div_start  = 1'b1;
          state_next = ST_DIV;
        end
      end
      ST_DIV:  if (div_done) state_next = ST_DONE;
      ST_DONE: if (!out_valid || out_xfer) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLR;
      clr_addr   <= '0;
      total      <= '0;
      out_valid  <= 1'b0;
      hue_levels <= HUE_RESET;
      sat_levels <= SAT_RESET;
      val_levels <= VAL_RESET;
    end else begin
      state <= state_next;

      if (state == ST_CLR) begin
        clr_addr <= clr_addr + 1'b1;
      end else if (in_xfer && cmd == CMD_CLEAR) begin
        clr_addr <= '0;
      end

      if (in_xfer && cmd == CMD_CLEAR) begin
        total <= '0;
      end else if (state == ST_WR && total != COUNT_MAX) begin
        total <= total + 1'b1;
      end

      if (state == ST_DONE && (!out_valid || out_xfer)) begin
        out_valid <= 1'b1;
      end else if (out_xfer) begin
        out_valid <= 1'b0;
      end

      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_HUE_LEVELS: hue_levels <= cfg_data[HUE_W-1:0];
          REG_SAT_LEVELS: sat_levels <= cfg_data[SAT_W-1:0];
          REG_VAL_LEVELS: val_levels <= cfg_data[VAL_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      cmd_r   <= cmd;
      hue_r   <= hue_q;
      sat_r   <= sat_q;
      val_r   <= val_q;
      rbin_r  <= read_bin;
      rbin_ok <= (read_bin < BIN_W'(NUM_BINS));
    end
    if (state == ST_IDX1) begin
      kind <= kind_next;
      t1   <= 7'(prod_sv) + {3'b000, sm2};
      hs   <= {4'd0, hue_use} * {5'd0, sat_use};
    end
    if (state == ST_IDX2) begin
      idx_color <= BIN_W'(prod_ht + {7'd0, hue_r - HUE_W'(1)});
      ncol      <= BIN_W'(prod_hsv);
    end
    if (state == ST_IDX3) begin
      case (kind)
        KIND_COLOR: bin_addr <= idx_color;
        KIND_GRAY:  bin_addr <= ncol + BIN_W'(val_r - VAL_W'(1));
        default:    bin_addr <= ncol;
      endcase
    end
    if (state == ST_LOAD) begin
      res_count <= rbin_ok ? rdata : '0;
      res_empty <= (total == '0);
    end
    if (state == ST_DONE && (!out_valid || out_xfer)) begin
      bin_id     <= rbin_r;
      bin_count  <= res_count;
      bin_share  <= res_empty ? '0 : quotient;
      empty_flag <= res_empty;
    end
  end

  // Bin RAM port selection
  always_comb begin
    we    = 1'b0;
    waddr = bin_addr;
    wdata = (rdata == COUNT_MAX) ? rdata : rdata + 1'b1;
    case (state)
      ST_CLR: begin
        we    = 1'b1;
        waddr = clr_addr;
        wdata = '0;
      end
      ST_WR:   we = 1'b1;
      default: we = 1'b0;
    endcase
  end

  assign raddr = (cmd_r == CMD_READ) ? (rbin_ok ? rbin_r : '0) : bin_addr;

  hsvh_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (NUM_BINS)
  ) u_bins (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Share = count * 2^16 / total, bit-serial
  hsvh_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (rbin_ok ? rdata : '0),
    .divisor  (total),
    .done     (div_done),
    .quotient (quotient)
  );

endmodule

@@ rtl/core/hsvh_ram.sv @@
module hsvh_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1033
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/core/hsvh_div.sv @@
module hsvh_div import hsvh_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [COUNT_BITS-1:0] dividend,
  input  logic [COUNT_BITS-1:0] divisor,
  output logic                  done,
  output logic [SHARE_W-1:0]    quotient
);

  logic                  busy;
  logic [STEP_W-1:0]     step;
  logic [COUNT_BITS-1:0] dvd;
  logic [COUNT_BITS-1:0] dsr;
  logic [COUNT_BITS-1:0] rem;
  logic [COUNT_BITS:0]   trial;
  logic                  fits;

  // Restoring step: shift in the next dividend bit, subtract if it fits.
  // Low bits past the dividend are zero, which gives the 2^16 scaling.
  assign trial = {rem, dvd[COUNT_BITS-1]};
  assign fits  = trial >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      if (start) begin
        busy <= 1'b1;
        done <= 1'b0;
      end else if (busy && step == STEP_W'(DIV_STEPS - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end else begin
        done <= 1'b0;
      end
    end
  end

  // Datapath; the quotient register keeps only the low bits
  always_ff @(posedge clk) begin
    if (start) begin
      dvd      <= dividend;
      dsr      <= divisor;
      rem      <= '0;
      step     <= '0;
      quotient <= '0;
    end else if (busy) begin
      dvd      <= {dvd[COUNT_BITS-2:0], 1'b0};
      rem      <= fits ? COUNT_BITS'(trial - {1'b0, dsr}) : trial[COUNT_BITS-1:0];
      quotient <= {quotient[SHARE_W-2:0], fits};
      step     <= step + 1'b1;
    end
  end

endmodule

@@ rtl/core/hsvh_checker.sv @@
module hsvh_checker import hsvh_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  in_valid,
  input logic                  in_stall,
  input logic [CMD_W-1:0]      cmd,
  input logic                  out_valid,
  input logic                  out_stall,
  input logic [BIN_W-1:0]      bin_id,
  input logic [COUNT_BITS-1:0] bin_count,
  input logic [SHARE_W-1:0]    bin_share,
  input logic                  empty_flag
);

  // Clearing pass holds off input right after reset
  a_reset_clears: assert property (@(posedge clk) rst |=> in_stall)
    else $error("input not stalled during clearing pass");

  // Any real command keeps the sequencer busy the next cycle
  a_busy_after_cmd: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && cmd != CMD_NOP) |=> in_stall)
    else $error("input taken while a command is in progress");

  // Empty histogram reports zero share
  a_empty_share: assert property (@(posedge clk) disable iff (rst)
    (out_valid && empty_flag) |-> (bin_share == '0))
    else $error("nonzero share on empty histogram");

  // Share never exceeds one
  a_share_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (bin_share <= SHARE_W'(1 << FRAC_W)))
    else $error("share above one");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(bin_id) &&
      $stable(bin_count) && $stable(bin_share) && $stable(empty_flag)))
    else $error("result changed while stalled");

endmodule

bind hsv_color_gray_histogram hsvh_checker u_checker (.*);
